### design/gsbd_pkg.sv
// ----------------------------------------------------------------------------
// gsbd_pkg - shared constants for the Golomb signed bit decoder
// Field widths, default sizes and reset values used by all decoder files.
// ----------------------------------------------------------------------------
package gsbd_pkg;

    // default counter and remainder sizes
    localparam int GSBD_QUOTIENT_BITS  = 16;
    localparam int GSBD_REMAINDER_BITS = 15;

    // fixed field widths on the channels
    localparam int GSBD_DIVISOR_W = 16;
    localparam int GSBD_VALUE_W   = 31;

    // divisor after reset
    localparam logic [GSBD_DIVISOR_W-1:0] GSBD_DIVISOR_RESET = 16'd2;

    // largest value before zigzag unmapping
    localparam logic [31:0] GSBD_VALUE_MAX = 32'h7FFF_FFFF;

    // codeword queue between front and back
    localparam int GSBD_QUEUE_DEPTH = 2;

endpackage

### design/gsbd_if.sv
// ----------------------------------------------------------------------------
// gsbd_if - channel interfaces of the Golomb signed bit decoder
// Code bit input, divisor write and decoded result channels (valid/ready).
// ----------------------------------------------------------------------------

// one code bit per request
interface gsbd_bit_if import gsbd_pkg::*; ();
    logic valid;
    logic ready;
    logic code_bit;

    modport source (output valid, output code_bit, input ready);
    modport sink   (input valid, input code_bit, output ready);
endinterface

// divisor register write
interface gsbd_cfg_if import gsbd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [GSBD_DIVISOR_W-1:0] golomb_divisor;

    modport source (output valid, output golomb_divisor, input ready);
    modport sink   (input valid, input golomb_divisor, output ready);
endinterface

// one decoded value per request
interface gsbd_res_if import gsbd_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [GSBD_VALUE_W-1:0] decoded_value;
    logic                           quotient_overflow;

    modport source (output valid, output decoded_value, output quotient_overflow, input ready);
    modport sink   (input valid, input decoded_value, input quotient_overflow, output ready);
endinterface

### design/golomb_signed_bit_decoder.sv
// ----------------------------------------------------------------------------
// golomb_signed_bit_decoder - bit-serial Golomb decoder, signed output
// Truncated-binary remainder, zigzag unmapping, saturating quotient.
// ----------------------------------------------------------------------------
// Usage:
//   i_bit  : one code bit per request, in stream order.
//   i_cfg  : divisor write (always ready); m is clamped to [2, 2^REMAINDER_BITS]
//            and b = ceil(log2 m) is derived at write time. Write only when idle.
//   o_res  : one signed value plus overflow flag per finished codeword.
// Throughput: one code bit per clock while i_bit.ready is high. A codeword has
//   at least two bits, so at most one result per two code bits.
// Path: a result passes the codeword queue, the multiply stage and the output
//   register after the last bit of its codeword is accepted.
// Stall: results wait in the output register, the multiply stage and a
//   two-entry codeword queue; i_bit.ready drops only once that queue is full.
// Reset: divisor returns to 2, codeword state and queue are cleared; no
//   clearing pass, input is ready on the first cycle after reset.
// ----------------------------------------------------------------------------
module golomb_signed_bit_decoder import gsbd_pkg::*; #(
    parameter int QUOTIENT_BITS  = GSBD_QUOTIENT_BITS,
    parameter int REMAINDER_BITS = GSBD_REMAINDER_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gsbd_bit_if.sink    i_bit,
    gsbd_cfg_if.sink    i_cfg,
    gsbd_res_if.source  o_res
);

    localparam int RW = QUOTIENT_BITS + 2 * REMAINDER_BITS + 2;

    logic          push_valid;
    logic          push_ready;
    logic [RW-1:0] push_data;
    logic          pop_valid;
    logic          pop_ready;
    logic [RW-1:0] pop_data;

    // bit parser
    gsbd_front #(
        .QUOTIENT_BITS  (QUOTIENT_BITS),
        .REMAINDER_BITS (REMAINDER_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bit        (i_bit),
        .i_cfg        (i_cfg),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    // codeword queue
    gsbd_queue #(
        .WIDTH (RW),
        .DEPTH (GSBD_QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    // value stage
    gsbd_back #(
        .QUOTIENT_BITS  (QUOTIENT_BITS),
        .REMAINDER_BITS (REMAINDER_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_res       (o_res)
    );

endmodule

### design/gsbd_front.sv
// ----------------------------------------------------------------------------
// gsbd_front - bit parser of the Golomb signed bit decoder
// Walks the unary run, truncated-binary remainder and extra bit one code bit
// per cycle while the queue has room; pushes a finished record (q, m, r, flag).
// ----------------------------------------------------------------------------
module gsbd_front import gsbd_pkg::*; #(
    parameter int QUOTIENT_BITS  = GSBD_QUOTIENT_BITS,
    parameter int REMAINDER_BITS = GSBD_REMAINDER_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gsbd_bit_if.sink     i_bit,
    gsbd_cfg_if.sink     i_cfg,
    output logic         o_push_valid,
    input  logic         i_push_ready,
    output logic [QUOTIENT_BITS+2*REMAINDER_BITS+1:0] o_push_data
);

    localparam int QB   = QUOTIENT_BITS;
    localparam int RB   = REMAINDER_BITS;
    localparam int MW   = RB + 1;
    localparam int CW   = $clog2(RB + 1);
    localparam int CMPW = (GSBD_DIVISOR_W > MW) ? GSBD_DIVISOR_W : MW;

    typedef enum logic [1:0] {
        PH_UNARY,
        PH_TRUNC,
        PH_EXTRA
    } t_phase;

    // codeword state
    t_phase          r_phase, n_phase;
    logic [QB-1:0]   r_q, n_q;
    logic            r_ovf, n_ovf;
    logic [RB-1:0]   r_acc, n_acc;
    logic [CW-1:0]   r_cnt, n_cnt;

    // divisor derived terms: effective m, width b, threshold t
    logic [MW-1:0]   r_m;
    logic [CW-1:0]   r_b;
    logic [RB-1:0]   r_t;
    logic [MW-1:0]   m_new;
    logic [CW-1:0]   b_new;
    logic [MW-1:0]   t_full;

    logic            accept;
    logic            emit;
    logic [RB-1:0]   emit_r;
    logic [RB-1:0]   acc_sh;
    logic [CW-1:0]   cnt_inc;
    logic [RB:0]     extra_r;
    logic [RB:0]     extra_d;

    assign i_cfg.ready = 1'b1;
    assign i_bit.ready = i_push_ready;
    assign accept      = i_bit.valid && i_push_ready;

    // divisor clamp and remainder width, taken once at write time
    always_comb begin
        logic [CMPW-1:0] raw_x;
        logic [CMPW-1:0] top_x;
        raw_x = CMPW'(i_cfg.golomb_divisor);
        top_x = CMPW'(1) << RB;
        if (raw_x < CMPW'(2)) begin
            m_new = MW'(2);
        end else if (raw_x > top_x) begin
            m_new = MW'(top_x);
        end else begin
            m_new = MW'(raw_x);
        end
        b_new = CW'(1);
        for (int k = 1; k < RB; k++) begin
            if ((MW'(1) << k) < m_new) begin
                b_new = CW'(k + 1);
            end
        end
        t_full = (MW'(1) << b_new) - m_new;
    end

    // remainder datapath
    assign acc_sh  = RB'({r_acc, i_bit.code_bit});
    assign cnt_inc = r_cnt + CW'(1);
    assign extra_r = {r_acc, i_bit.code_bit};
    assign extra_d = extra_r - {1'b0, r_t};

    // phase walk for one accepted bit
    always_comb begin
        n_phase = r_phase;
        n_q     = r_q;
        n_ovf   = r_ovf;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        emit    = 1'b0;
        emit_r  = '0;
        case (r_phase)
            PH_UNARY: begin
                if (i_bit.code_bit) begin
                    if (r_q == '1) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_q = r_q + QB'(1);
                    end
                end else begin
                    n_acc = '0;
                    n_cnt = '0;
                    if (r_b == CW'(1)) begin
                        // no truncated bits: decide on an empty remainder
                        if (r_t == '0) begin
                            n_phase = PH_EXTRA;
                        end else begin
                            emit = 1'b1;
                        end
                    end else begin
                        n_phase = PH_TRUNC;
                    end
                end
            end
            PH_TRUNC: begin
                n_acc = acc_sh;
                n_cnt = cnt_inc;
                if (cnt_inc >= r_b - CW'(1)) begin
                    if (acc_sh >= r_t) begin
                        n_phase = PH_EXTRA;
                    end else begin
                        emit   = 1'b1;
                        emit_r = acc_sh;
                    end
                end
            end
            PH_EXTRA: begin
                emit = 1'b1;
                if (extra_r >= {1'b0, r_t}) begin
                    emit_r = extra_d[RB-1:0];
                end
            end
            default: begin
                n_phase = PH_UNARY;
            end
        endcase
        // codeword done: start over
        if (emit) begin
            n_phase = PH_UNARY;
            n_q     = '0;
            n_ovf   = 1'b0;
            n_acc   = '0;
            n_cnt   = '0;
        end
    end

    assign o_push_valid = accept && emit;
    assign o_push_data  = {r_q, r_m, emit_r, r_ovf};

    // state and divisor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_UNARY;
            r_q     <= '0;
            r_ovf   <= 1'b0;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_m     <= MW'(GSBD_DIVISOR_RESET);
            r_b     <= CW'(1);
            r_t     <= '0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_q     <= n_q;
                r_ovf   <= n_ovf;
                r_acc   <= n_acc;
                r_cnt   <= n_cnt;
            end
            if (i_cfg.valid) begin
                r_m <= m_new;
                r_b <= b_new;
                r_t <= t_full[RB-1:0];
            end
        end
    end

endmodule

### design/gsbd_queue.sv
// ----------------------------------------------------------------------------
// gsbd_queue - codeword queue of the Golomb signed bit decoder
// Small register FIFO that decouples the bit parser from the value stage.
// ----------------------------------------------------------------------------
module gsbd_queue import gsbd_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = GSBD_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [NW-1:0]    r_cnt;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_cnt != NW'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

### design/gsbd_back.sv
// ----------------------------------------------------------------------------
// gsbd_back - value stage of the Golomb signed bit decoder
// Multiplies q by m, adds r, clamps to 31 bits and undoes the zigzag map.
// Two registered stages with stall flowing back from the result channel.
// ----------------------------------------------------------------------------
module gsbd_back import gsbd_pkg::*; #(
    parameter int QUOTIENT_BITS  = GSBD_QUOTIENT_BITS,
    parameter int REMAINDER_BITS = GSBD_REMAINDER_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_pop_valid,
    output logic         o_pop_ready,
    input  logic [QUOTIENT_BITS+2*REMAINDER_BITS+1:0] i_pop_data,
    gsbd_res_if.source   o_res
);

    localparam int QB = QUOTIENT_BITS;
    localparam int RB = REMAINDER_BITS;
    localparam int MW = RB + 1;
    localparam int RW = QB + MW + RB + 1;
    localparam int PW = QB + MW;
    localparam int VW = (PW + 1 > 32) ? PW + 1 : 32;

    // record fields
    logic [QB-1:0] in_q;
    logic [MW-1:0] in_m;
    logic [RB-1:0] in_r;
    logic          in_ovf;

    assign in_q   = i_pop_data[RW-1 -: QB];
    assign in_m   = i_pop_data[RW-QB-1 -: MW];
    assign in_r   = i_pop_data[RB:1];
    assign in_ovf = i_pop_data[0];

    // stage 1: product
    logic          r_s1_v;
    logic [PW-1:0] r_prod;
    logic [RB-1:0] r_s1_r;
    logic          r_s1_ovf;

    // stage 2: output register
    logic                    r_out_v;
    logic [GSBD_VALUE_W-1:0] r_val;
    logic                    r_flag;

    logic                    out_adv;
    logic                    s1_adv;
    logic [VW-1:0]           v_sum;
    logic                    v_over;
    logic [GSBD_VALUE_W-1:0] v_clamp;
    logic [GSBD_VALUE_W-1:0] v_half;
    logic [GSBD_VALUE_W-1:0] v_zig;

    assign out_adv     = !r_out_v || o_res.ready;
    assign s1_adv      = !r_s1_v || out_adv;
    assign o_pop_ready = s1_adv;

    // add remainder, clamp, zigzag unmap
    assign v_sum   = VW'(r_prod) + VW'(r_s1_r);
    assign v_over  = v_sum > VW'(GSBD_VALUE_MAX);
    assign v_clamp = v_over ? '1 : v_sum[GSBD_VALUE_W-1:0];
    assign v_half  = {1'b0, v_clamp[GSBD_VALUE_W-1:1]};
    assign v_zig   = v_clamp[0] ? ~v_half : v_half;

    assign o_res.valid             = r_out_v;
    assign o_res.decoded_value     = r_val;
    assign o_res.quotient_overflow = r_flag;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (out_adv) begin
                r_out_v <= r_s1_v;
            end
            if (s1_adv) begin
                r_s1_v <= i_pop_valid;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (out_adv && r_s1_v) begin
            r_val  <= v_zig;
            r_flag <= r_s1_ovf || v_over;
        end
        if (s1_adv && i_pop_valid) begin
            r_prod   <= PW'(in_q) * PW'(in_m);
            r_s1_r   <= in_r;
            r_s1_ovf <= in_ovf;
        end
    end

endmodule

### design/gsbd_checker.sv
// ----------------------------------------------------------------------------
// gsbd_checker - port checks for the Golomb signed bit decoder
// Reset behavior, input readiness and result hold under stall, bound to the top level.
// ----------------------------------------------------------------------------
module gsbd_checker import gsbd_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [GSBD_VALUE_W-1:0] i_out_value,
    input logic                    i_out_flag
);

    // a codeword needs two bits plus queue and multiply stage: no early result
    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid ##1 !i_out_valid ##1 !i_out_valid)
        else $error("result valid too soon after reset");

    // empty queue after reset takes a bit right away
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

    // checks that an offered bit is taken once the output is free and not stalled
    a_take_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid && $past(!i_out_valid) && $past(!i_out_valid, 2)
        && $past(i_rst_n, 3) |-> i_in_ready || !i_in_valid)
        else $error("input stalled with an empty pipeline");

    // stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value)
        && $stable(i_out_flag))
        else $error("result changed while stalled");

endmodule

bind golomb_signed_bit_decoder gsbd_checker u_gsbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_bit.valid),
    .i_in_ready  (i_bit.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_value (o_res.decoded_value),
    .i_out_flag  (o_res.quotient_overflow)
);

### sim/golomb_signed_bit_decoder_tb.sv
// ----------------------------------------------------------------------------
// golomb_signed_bit_decoder_tb - self-checking bench for the Golomb bit decoder
// Drives code bits and divisor writes over the valid/ready channels, predicts
// every decoded value with a bit-level model of the decoder, and compares each
// returned value and overflow flag in order. A directed plan covers the field
// extremes, divisor clamping and long unary runs; random codeword streams
// with noise, random idle gaps and a long output hold-off follow.
// ----------------------------------------------------------------------------
module golomb_signed_bit_decoder_tb;
    import gsbd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QB           = GSBD_QUOTIENT_BITS;
    localparam int RB           = GSBD_REMAINDER_BITS;
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_BITS  = 980;
    localparam int MAX_PRINTS   = 30;
    localparam longint RUN_LIMIT_NS = 64'd20_000_000;

    typedef enum logic [1:0] {UNARY_RUN, TRUNC_BITS, EXTRA_BIT} t_decode_phase;
    typedef enum logic {ROW_BITS, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic signed [GSBD_VALUE_W-1:0] value;
        logic                           ovf;
    } t_decode;

    typedef struct packed {
        t_row_kind                 kind;
        logic [GSBD_DIVISOR_W-1:0] divisor;
        logic                      code_bit;
        int                        reps;
        logic                      typed;
        logic [GSBD_VALUE_W-1:0]   exp_value;
        logic                      exp_ovf;
    } t_plan_row;

    // directed plan: typed results only where they follow at a glance
    localparam int PLAN_ROWS = 32;
    localparam t_plan_row PLAN [0:PLAN_ROWS-1] = '{
        // divisor 2 after reset: zero, a negative value, a longer unary run
        '{ROW_BITS, 16'd0,     1'b0, 1,     1'b0, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b0, 1,     1'b1, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b1, 1,     1'b0, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b0, 1,     1'b0, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b1, 1,     1'b1, -31'sd2,        1'b0},
        '{ROW_BITS, 16'd0,     1'b1, 20,    1'b0, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b0, 1,     1'b0, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b0, 1,     1'b1, 31'd20,         1'b0},
        // divisor 3: short and long truncated codes
        '{ROW_CFG,  16'd3,     1'b0, 1,     1'b0, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b0, 2,     1'b0, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b0, 1,     1'b0, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b1, 1,     1'b0, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b0, 1,     1'b0, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b0, 1,     1'b0, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b1, 2,     1'b0, 31'd0,          1'b0},
        // divisor 5
        '{ROW_CFG,  16'd5,     1'b0, 1,     1'b0, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b1, 2,     1'b0, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b0, 1,     1'b0, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b1, 3,     1'b0, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b0, 2,     1'b0, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b1, 1,     1'b0, 31'd0,          1'b0},
        // divisor below range acts as 2
        '{ROW_CFG,  16'd0,     1'b0, 1,     1'b0, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b0, 1,     1'b0, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b1, 1,     1'b1, -31'sd1,        1'b0},
        // divisor above range acts as 2^15, all-ones remainder
        '{ROW_CFG,  16'hFFFF,  1'b0, 1,     1'b0, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b0, 1,     1'b0, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b1, 15,    1'b1, -31'sd16384,    1'b0},
        // power of two: extra bit always read
        '{ROW_CFG,  16'd16,    1'b0, 1,     1'b0, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b1, 1,     1'b0, 31'd0,          1'b0},
        // largest divisor with a long unary run
        '{ROW_CFG,  16'd32768, 1'b0, 1,     1'b0, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b1, 40,    1'b0, 31'd0,          1'b0},
        '{ROW_BITS, 16'd0,     1'b0, 1,     1'b0, 31'd0,          1'b0}
    };

    logic clk;
    logic rst_n;

    gsbd_bit_if bit_ch ();
    gsbd_cfg_if cfg_ch ();
    gsbd_res_if res_ch ();

    golomb_signed_bit_decoder dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_bit   (bit_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    // predictor state
    logic [GSBD_DIVISOR_W-1:0] divisor_reg;
    t_decode_phase             phase_s;
    logic [QB-1:0]             quot_cnt;
    logic                      quot_sat;
    logic [RB-1:0]             rem_acc;
    logic [3:0]                rem_read;

    t_decode expected_decodes [$];

    int error_count    = 0;
    int bits_sent      = 0;
    int values_checked = 0;
    int divisor_writes = 0;
    int holds_asked    = 0;
    bit tx_calm        = 1'b0;
    bit rx_calm        = 1'b0;

    // clock
    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("golomb_signed_bit_decoder verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    // divisor as the decoder uses it
    function automatic int unsigned eff_divisor(input logic [GSBD_DIVISOR_W-1:0] m);
        if (m < 2)
            return 2;
        if (m > (32'd1 << RB))
            return 32'd1 << RB;
        return 32'(m);
    endfunction

    // remainder width b = ceil(log2 m), at least 1
    function automatic int unsigned rem_width(input int unsigned m);
        int unsigned b;
        b = 1;
        while (b < RB && (32'd1 << b) < m)
            b++;
        return b;
    endfunction

    task automatic clear_codeword();
        phase_s  = UNARY_RUN;
        quot_cnt = '0;
        quot_sat = 1'b0;
        rem_acc  = '0;
        rem_read = '0;
    endtask

    // v = q*m + r, clamped, then zigzag unmapped
    task automatic finish_codeword(input int unsigned m, input int unsigned r,
                                   output t_decode res);
        longint unsigned v;
        longint unsigned half;
        v = 64'(quot_cnt) * 64'(m) + 64'(r);
        res.ovf = quot_sat;
        if (v > 64'(GSBD_VALUE_MAX)) begin
            v = 64'(GSBD_VALUE_MAX);
            res.ovf = 1'b1;
        end
        if (!v[0]) begin
            res.value = v[31:1];
        end else begin
            half = (v + 1) >> 1;
            res.value = 31'(64'd0 - half);
        end
        clear_codeword();
    endtask

    // truncated bits complete: end here or go on to the extra bit
    task automatic close_trunc(input int unsigned m, input int unsigned t,
                               output logic got, output t_decode res);
        got = 1'b0;
        res = '0;
        if (rem_acc >= t) begin
            phase_s = EXTRA_BIT;
        end else begin
            finish_codeword(m, 32'(rem_acc), res);
            got = 1'b1;
        end
    endtask

    // advance the decoder model by one code bit
    task automatic decode_code_bit(input logic bit_val, output logic got,
                                   output t_decode res);
        int unsigned m;
        int unsigned b;
        int unsigned t;
        int unsigned r;
        m   = eff_divisor(divisor_reg);
        b   = rem_width(m);
        t   = (32'd1 << b) - m;
        got = 1'b0;
        res = '0;
        case (phase_s)
            TRUNC_BITS: begin
                rem_acc  = {rem_acc[RB-2:0], bit_val};
                rem_read = rem_read + 4'd1;
                if (rem_read >= b - 1)
                    close_trunc(m, t, got, res);
            end
            EXTRA_BIT: begin
                r = 32'({rem_acc, bit_val});
                r = (r >= t) ? r - t : 0;
                finish_codeword(m, r, res);
                got = 1'b1;
            end
            default: begin
                if (bit_val) begin
                    if (quot_cnt == '1)
                        quot_sat = 1'b1;
                    else
                        quot_cnt = quot_cnt + QB'(1);
                end else begin
                    rem_acc  = '0;
                    rem_read = '0;
                    phase_s  = TRUNC_BITS;
                    if (b == 1)
                        close_trunc(m, t, got, res);
                end
            end
        endcase
    endtask

    // idle length: mostly short, a few long
    function automatic int pick_idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // offer one code bit; entered and left at a falling edge with valid held
    task automatic push_bit(input logic bit_val, input logic typed, input t_decode typed_res);
        int      gap;
        logic    got;
        t_decode res;
        gap = 0;
        if (!tx_calm && $urandom_range(0, 99) < 25)
            gap = pick_idle_len();
        if (gap > 0) begin
            bit_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        bit_ch.valid    <= 1'b1;
        bit_ch.code_bit <= bit_val;
        do @(posedge clk); while (!bit_ch.ready);
        bits_sent++;
        decode_code_bit(bit_val, got, res);
        if (got)
            expected_decodes.push_back(typed ? typed_res : res);
        else if (typed)
            report_mismatch("plan row expects a finished codeword");
        @(negedge clk);
    endtask

    // finish any partial codeword, drain results, then write the divisor
    task automatic write_divisor(input logic [GSBD_DIVISOR_W-1:0] m);
        while (!(phase_s == UNARY_RUN && quot_cnt == 0 && !quot_sat))
            push_bit(1'b0, 1'b0, '0);
        bit_ch.valid <= 1'b0;
        while (expected_decodes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.golomb_divisor <= m;
        do @(posedge clk); while (!cfg_ch.ready);
        divisor_reg = m;
        divisor_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // one well-formed codeword with random quotient and remainder
    task automatic send_codeword();
        int unsigned m;
        int unsigned b;
        int unsigned t;
        int unsigned q;
        int unsigned r;
        int unsigned code;
        int unsigned len;
        m = eff_divisor(divisor_reg);
        b = rem_width(m);
        t = (32'd1 << b) - m;
        q = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
        r = $urandom_range(0, m - 1);
        if (r < t) begin
            code = r;
            len  = b - 1;
        end else begin
            code = r + t;
            len  = b;
        end
        repeat (q) push_bit(1'b1, 1'b0, '0);
        push_bit(1'b0, 1'b0, '0);
        for (int i = int'(len) - 1; i >= 0; i--)
            push_bit(code[i], 1'b0, '0);
    endtask

    function automatic logic [GSBD_DIVISOR_W-1:0] pick_divisor();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(2, 12));
            1: return 16'd1 << $urandom_range(1, 15);
            2: return 16'($urandom_range(0, 1));
            3: return 16'($urandom_range(32768, 65535));
            4: return 16'($urandom_range(13, 32767));
            default: return 16'($urandom_range(2, 300));
        endcase
    endfunction

    // result receiver: random stalls plus an occasional long hold-off
    initial begin
        int   stall_left;
        int   hold_left;
        int   holds_served;
        logic rdy;
        stall_left   = 0;
        hold_left    = 0;
        holds_served = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (holds_served != holds_asked) begin
                holds_served = holds_asked;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                rdy = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                rdy = 1'b0;
                stall_left--;
            end else if (!rx_calm && $urandom_range(0, 99) < 20) begin
                rdy = 1'b0;
                stall_left = pick_idle_len() - 1;
            end else begin
                rdy = 1'b1;
            end
            res_ch.ready <= rdy;
        end
    end

    // result checker
    always @(posedge clk) begin
        t_decode want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            values_checked++;
            if (expected_decodes.size() == 0) begin
                report_mismatch($sformatf("value %0d with no codeword pending",
                                          res_ch.decoded_value));
            end else begin
                want = expected_decodes.pop_front();
                if (res_ch.decoded_value !== want.value)
                    report_mismatch($sformatf("decoded_value %0d, expected %0d",
                                              res_ch.decoded_value, want.value));
                if (res_ch.quotient_overflow !== want.ovf)
                    report_mismatch($sformatf("quotient_overflow %0b, expected %0b",
                                              res_ch.quotient_overflow, want.ovf));
            end
        end
    end

    // stimulus
    initial begin
        int      phase_no;
        int      random_stop;
        int      stop_here;
        t_decode typed_res;
        rst_n                 = 1'b0;
        bit_ch.valid          = 1'b0;
        bit_ch.code_bit       = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.golomb_divisor = '0;
        divisor_reg           = GSBD_DIVISOR_RESET;
        clear_codeword();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed plan
        for (int i = 0; i < PLAN_ROWS; i++) begin
            if (PLAN[i].kind == ROW_CFG) begin
                write_divisor(PLAN[i].divisor);
            end else begin
                tx_calm = (PLAN[i].reps > 100);
                rx_calm = tx_calm;
                typed_res.value = PLAN[i].exp_value;
                typed_res.ovf   = PLAN[i].exp_ovf;
                for (int k = 0; k < PLAN[i].reps; k++)
                    push_bit(PLAN[i].code_bit, PLAN[i].typed && (k == PLAN[i].reps - 1),
                             typed_res);
            end
            // close the power-of-two codeword
            if (i == 28) begin
                push_bit(1'b0, 1'b0, '0);
                push_bit(1'b1, 1'b0, '0);
                push_bit(1'b0, 1'b0, '0);
                push_bit(1'b1, 1'b0, '0);
                push_bit(1'b0, 1'b0, '0);
            end
        end
        // finish the long-run codeword with an all-ones remainder
        for (int k = 0; k < 15; k++)
            push_bit(1'b1, 1'b0, '0);
        // divisor just below the top: all-zero truncated code
        write_divisor(16'd32767);
        repeat (15) push_bit(1'b0, 1'b0, '0);

        // random codeword streams with noise, one divisor per phase
        phase_no    = 0;
        random_stop = bits_sent + RANDOM_BITS;
        while (bits_sent < random_stop) begin
            write_divisor(phase_no == 0 ? 16'($urandom_range(2, 6)) : pick_divisor());
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if (phase_no == 0) begin
                // output held off while the sender keeps offering bits
                tx_calm = 1'b1;
                holds_asked++;
            end
            stop_here = bits_sent + $urandom_range(60, 160);
            if (stop_here > random_stop)
                stop_here = random_stop;
            while (bits_sent < stop_here) begin
                if ($urandom_range(0, 99) < 8)
                    repeat ($urandom_range(1, 3))
                        push_bit(1'($urandom_range(0, 1)), 1'b0, '0);
                else
                    send_codeword();
            end
            phase_no++;
        end

        // drain and finish
        bit_ch.valid <= 1'b0;
        while (expected_decodes.size() != 0)
            @(negedge clk);
        repeat (2 * DRAIN_CYCLES) @(negedge clk);
        $display("Covered %0d code bits across %0d divisor settings;",
                 bits_sent, divisor_writes);
        $display("%0d decoded values compared.", values_checked);
        if (error_count == 0)
            $display("golomb_signed_bit_decoder verification clean");
        else
            $display("golomb_signed_bit_decoder verification failed");
        $finish;
    end

endmodule

### filelist.f
design/gsbd_pkg.sv
design/gsbd_if.sv
design/gsbd_front.sv
design/gsbd_queue.sv
design/gsbd_back.sv
design/golomb_signed_bit_decoder.sv
design/gsbd_checker.sv
sim/golomb_signed_bit_decoder_tb.sv
